// File: rtl/mccs_pkg.sv
// ----------------------------------------------------------------------------
// mccs_pkg: shared definitions for the minimum coin change solver
// Widths, table constants, register indexes and the control/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mccs_pkg;

  localparam int MAX_AMOUNT = 1023;
  localparam int MAX_DENOMS = 6;
  localparam int NUM_SLOTS  = 6;

  localparam int AMT_W  = 10;  // amounts, denominations, bill counts
  localparam int TBL_W  = 11;  // table entries, wide enough for the infinity mark
  localparam int SLOT_W = 3;   // slot index, can also hold NUM_SLOTS
  localparam int DCNT_W = 3;   // denom_count register
  localparam int DEPTH  = MAX_AMOUNT + 1;

  localparam logic [TBL_W-1:0] TBL_INF = TBL_W'(MAX_AMOUNT + 1);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_DENOM_COUNT = 3'd0,
    REG_DENOM_0     = 3'd1,
    REG_DENOM_1     = 3'd2,
    REG_DENOM_2     = 3'd3,
    REG_DENOM_3     = 3'd4,
    REG_DENOM_4     = 3'd5,
    REG_DENOM_5     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DCNT_W-1:0]                denom_count;
    logic [NUM_SLOTS-1:0][AMT_W-1:0]  denom;
  } cfg_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FILL    = 6'b000010,
    S_FILL_WR = 6'b000100,
    S_CHECK   = 6'b001000,
    S_RT      = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic fill_step;
    logic fill_wr;
    logic rt_load;
    logic rt_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic target_zero;
    logic fill_last_slot;
    logic fill_last_amt;
    logic solvable;
    logic rem_zero;
    logic rt_hit;
    logic rt_miss;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/mccs_cfg.sv
// ----------------------------------------------------------------------------
// mccs_cfg: configuration register file
// APB-style slave holding the slot count and the six denomination values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mccs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mccs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mccs_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mccs_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output mccs_pkg::cfg_t                     cfg
);

  mccs_pkg::cfg_t     cfg_r, cfg_nxt;
  mccs_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign reg_idx = mccs_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        mccs_pkg::REG_DENOM_COUNT: cfg_nxt.denom_count = pwdata[mccs_pkg::DCNT_W-1:0];
        mccs_pkg::REG_DENOM_0:     cfg_nxt.denom[0]    = pwdata[mccs_pkg::AMT_W-1:0];
        mccs_pkg::REG_DENOM_1:     cfg_nxt.denom[1]    = pwdata[mccs_pkg::AMT_W-1:0];
        mccs_pkg::REG_DENOM_2:     cfg_nxt.denom[2]    = pwdata[mccs_pkg::AMT_W-1:0];
        mccs_pkg::REG_DENOM_3:     cfg_nxt.denom[3]    = pwdata[mccs_pkg::AMT_W-1:0];
        mccs_pkg::REG_DENOM_4:     cfg_nxt.denom[4]    = pwdata[mccs_pkg::AMT_W-1:0];
        mccs_pkg::REG_DENOM_5:     cfg_nxt.denom[5]    = pwdata[mccs_pkg::AMT_W-1:0];
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mccs_pkg::REG_DENOM_COUNT: prdata = mccs_pkg::PDATA_W'(cfg_r.denom_count);
      mccs_pkg::REG_DENOM_0:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[0]);
      mccs_pkg::REG_DENOM_1:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[1]);
      mccs_pkg::REG_DENOM_2:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[2]);
      mccs_pkg::REG_DENOM_3:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[3]);
      mccs_pkg::REG_DENOM_4:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[4]);
      mccs_pkg::REG_DENOM_5:     prdata = mccs_pkg::PDATA_W'(cfg_r.denom[5]);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.denom_count <= mccs_pkg::DCNT_W'(1);
      for (int i = 0; i < mccs_pkg::NUM_SLOTS; i++) begin
        cfg_r.denom[i] <= mccs_pkg::AMT_W'(1);
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mccs_ctrl.sv
// ----------------------------------------------------------------------------
// mccs_ctrl: solver sequencer
// Steps the datapath through table fill, retrace and result hand-off, and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mccs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire mccs_pkg::stat_t stat,
  output mccs_pkg::cmd_t       cmd
);

  mccs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == mccs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      mccs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mccs_pkg::S_FILL;
        end
      end
      mccs_pkg::S_FILL: begin
        if (stat.target_zero) begin
          state_nxt = mccs_pkg::S_CHECK;
        end else begin
          cmd.fill_step = 1'b1;
          if (stat.fill_last_slot) begin
            state_nxt = mccs_pkg::S_FILL_WR;
          end
        end
      end
      mccs_pkg::S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = stat.fill_last_amt ? mccs_pkg::S_CHECK : mccs_pkg::S_FILL;
      end
      mccs_pkg::S_CHECK: begin
        cmd.rt_load = 1'b1;
        state_nxt   = stat.solvable ? mccs_pkg::S_RT : mccs_pkg::S_DONE;
      end
      mccs_pkg::S_RT: begin
        if (stat.rem_zero) begin
          state_nxt = mccs_pkg::S_DONE;
        end else begin
          cmd.rt_step = 1'b1;
          if (stat.rt_miss) begin
            state_nxt = mccs_pkg::S_DONE;
          end
        end
      end
      mccs_pkg::S_DONE: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mccs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mccs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mccs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The write-back of an amount always closes a run of slot reads.
  a_wr_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mccs_pkg::S_FILL_WR) |-> $past(state_r == mccs_pkg::S_FILL))
    else $error("fill write-back without preceding slot reads");

  // A new result is never published over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result published over a pending beat");

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

endmodule

`default_nettype wire

// File: rtl/mccs_dp.sv
// ----------------------------------------------------------------------------
// mccs_dp: solver datapath
// Holds the fewest-bills table memory, the amount and slot counters, the
// running minimum, the retrace counters and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mccs_dp (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire mccs_pkg::cfg_t                                cfg,
  input  wire mccs_pkg::cmd_t                                cmd,
  input  wire logic [mccs_pkg::AMT_W-1:0]                    in_target_amount,
  output mccs_pkg::stat_t                                    stat,
  output logic                                               res_solvable,
  output logic [mccs_pkg::AMT_W-1:0]                         res_total,
  output logic [mccs_pkg::NUM_SLOTS-1:0][mccs_pkg::AMT_W-1:0] res_count
);

  logic [mccs_pkg::TBL_W-1:0] tbl_mem [mccs_pkg::DEPTH];

  logic [mccs_pkg::AMT_W-1:0]  target_r, target_nxt, m_r, m_nxt, rem_r, rem_nxt;
  logic [mccs_pkg::SLOT_W-1:0] slot_r, slot_nxt, pend_slot_r, pend_slot_nxt;
  logic                        pend_r, pend_nxt;
  logic [mccs_pkg::TBL_W-1:0]  best_r, best_nxt, cur_r, cur_nxt, tot_r, tot_nxt;
  logic [mccs_pkg::TBL_W-1:0]  rd_data_r;
  logic [mccs_pkg::NUM_SLOTS-1:0][mccs_pkg::AMT_W-1:0] cnt_r, cnt_nxt;

  logic                                               sol_r, sol_nxt;
  logic [mccs_pkg::AMT_W-1:0]                         total_r, total_nxt;
  logic [mccs_pkg::NUM_SLOTS-1:0][mccs_pkg::AMT_W-1:0] rcnt_r, rcnt_nxt;

  logic                        slot_in_range, usable, hit;
  logic [mccs_pkg::DCNT_W-1:0] n_use;
  logic [mccs_pkg::AMT_W-1:0]  d_iss, d_hit, key, rd_addr;
  logic [mccs_pkg::TBL_W-1:0]  cand, best_cmp;
  logic                        wr_en;
  logic [mccs_pkg::AMT_W-1:0]  wr_addr;
  logic [mccs_pkg::TBL_W-1:0]  wr_data;

  // Slot issue side: one table read per cycle, compared in the cycle after its issue.
  assign slot_in_range = (slot_r < mccs_pkg::SLOT_W'(mccs_pkg::NUM_SLOTS));
  assign n_use = (cfg.denom_count > mccs_pkg::DCNT_W'(mccs_pkg::MAX_DENOMS)) ?
                 mccs_pkg::DCNT_W'(mccs_pkg::MAX_DENOMS) : cfg.denom_count;
  assign d_iss   = slot_in_range ? cfg.denom[slot_r] : '0;
  assign key     = cmd.rt_step ? rem_r : m_r;
  assign usable  = slot_in_range && (slot_r < n_use) && (d_iss != '0) && (d_iss <= key);
  assign rd_addr = key - d_iss;

  assign cand     = rd_data_r + mccs_pkg::TBL_W'(1);
  assign best_cmp = (pend_r && (cand < best_r)) ? cand : best_r;
  assign hit      = pend_r && (cand == cur_r);
  assign d_hit    = cfg.denom[pend_slot_r];

  assign wr_en   = cmd.load || cmd.fill_wr;
  assign wr_addr = cmd.load ? '0 : m_r;
  assign wr_data = cmd.load ? '0 : best_cmp;

  assign stat.target_zero    = (target_r == '0);
  assign stat.fill_last_slot = (slot_r == mccs_pkg::SLOT_W'(mccs_pkg::NUM_SLOTS - 1));
  assign stat.fill_last_amt  = (m_r == target_r);
  assign stat.solvable       = (cur_r < mccs_pkg::TBL_INF);
  assign stat.rem_zero       = (rem_r == '0);
  assign stat.rt_hit         = hit;
  assign stat.rt_miss        = !slot_in_range && !hit;

  assign res_solvable = sol_r;
  assign res_total    = total_r;
  assign res_count    = rcnt_r;

  always_comb begin
    target_nxt    = target_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    slot_nxt      = slot_r;
    pend_slot_nxt = pend_slot_r;
    pend_nxt      = pend_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    sol_nxt       = sol_r;
    total_nxt     = total_r;
    rcnt_nxt      = rcnt_r;

    if (cmd.load) begin
      target_nxt = in_target_amount;
      m_nxt      = mccs_pkg::AMT_W'(1);
      slot_nxt   = '0;
      pend_nxt   = 1'b0;
      best_nxt   = mccs_pkg::TBL_INF;
      cur_nxt    = '0;
      cnt_nxt    = '0;
    end

    if (cmd.fill_step) begin
      best_nxt      = best_cmp;
      pend_nxt      = usable;
      pend_slot_nxt = slot_r;
      slot_nxt      = slot_r + mccs_pkg::SLOT_W'(1);
    end

    if (cmd.fill_wr) begin
      cur_nxt  = best_cmp;
      m_nxt    = m_r + mccs_pkg::AMT_W'(1);
      slot_nxt = '0;
      pend_nxt = 1'b0;
      best_nxt = mccs_pkg::TBL_INF;
    end

    if (cmd.rt_load) begin
      rem_nxt  = target_r;
      slot_nxt = '0;
      pend_nxt = 1'b0;
      tot_nxt  = cur_r;
    end

    if (cmd.rt_step) begin
      if (hit) begin
        // Take this slot and restart the scan at slot 0; the read that was
        // issued in this cycle used the old remainder and is dropped.
        cnt_nxt[pend_slot_r] = cnt_r[pend_slot_r] + mccs_pkg::AMT_W'(1);
        rem_nxt  = rem_r - d_hit;
        cur_nxt  = cur_r - mccs_pkg::TBL_W'(1);
        slot_nxt = '0;
        pend_nxt = 1'b0;
      end else if (slot_in_range) begin
        pend_nxt      = usable;
        pend_slot_nxt = slot_r;
        slot_nxt      = slot_r + mccs_pkg::SLOT_W'(1);
      end else begin
        pend_nxt = 1'b0;
      end
    end

    if (cmd.publish) begin
      sol_nxt   = (tot_r < mccs_pkg::TBL_INF);
      total_nxt = (tot_r < mccs_pkg::TBL_INF) ? tot_r[mccs_pkg::AMT_W-1:0] : '0;
      rcnt_nxt  = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      pend_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    m_r         <= m_nxt;
    rem_r       <= rem_nxt;
    pend_slot_r <= pend_slot_nxt;
    best_r      <= best_nxt;
    cur_r       <= cur_nxt;
    tot_r       <= tot_nxt;
    cnt_r       <= cnt_nxt;
    sol_r       <= sol_nxt;
    total_r     <= total_nxt;
    rcnt_r      <= rcnt_nxt;
  end

  // A table entry never exceeds the infinity mark.
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_wr |-> (best_cmp <= mccs_pkg::TBL_INF))
    else $error("table entry above infinity mark");

  // A retrace hit takes a nonzero bill that fits the remainder.
  a_hit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rt_step && hit) |-> ((d_hit != '0) && (d_hit <= rem_r)))
    else $error("retrace took a bill that does not fit");

  // A hit always consumes one of a positive number of remaining bills.
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rt_step && hit) |-> (cur_r != '0))
    else $error("retrace hit with no bills left");

endmodule

`default_nettype wire

// File: rtl/min_coin_change_solver.sv
// ----------------------------------------------------------------------------
// min_coin_change_solver: fewest-bill payout solver
// Top level joining the register file, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One request is worked on at a time. For a target T the block fills a table
// of fewest bills for every amount 1..T, each amount taking six slot reads
// through the single read port of the table memory plus one write-back, then
// retraces from T at one slot read per cycle, restarting from slot 0 after
// each bill taken. A zero target skips the table fill. The next request is
// accepted as soon as the result beat has been loaded into the output register,
// even while that beat still waits for out_ready. Configuration must only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_coin_change_solver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mccs_pkg::AMT_W-1:0]    in_target_amount,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_solvable,
  output logic      [mccs_pkg::AMT_W-1:0]    out_total_bills,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot0,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot1,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot2,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot3,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot4,
  output logic      [mccs_pkg::AMT_W-1:0]    out_count_slot5,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mccs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mccs_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mccs_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  mccs_pkg::cfg_t  cfg;
  mccs_pkg::cmd_t  cmd;
  mccs_pkg::stat_t stat;
  logic [mccs_pkg::NUM_SLOTS-1:0][mccs_pkg::AMT_W-1:0] res_count;

  mccs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mccs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .in_target_amount (in_target_amount),
    .stat             (stat),
    .res_solvable     (out_solvable),
    .res_total        (out_total_bills),
    .res_count        (res_count)
  );

  assign out_count_slot0 = res_count[0];
  assign out_count_slot1 = res_count[1];
  assign out_count_slot2 = res_count[2];
  assign out_count_slot3 = res_count[3];
  assign out_count_slot4 = res_count[4];
  assign out_count_slot5 = res_count[5];

endmodule

`default_nettype wire
